/* rtl/jas_pkg.sv */
// Package for the joystick axis shaper: state codes, register map, reset values.
package jas_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_POST,
        ST_DONE
    } jas_state_t;

    typedef enum logic [1:0] {
        OP_CAL,
        OP_LIN,
        OP_SQR,
        OP_SQR_FIN
    } jas_op_t;

    localparam logic [2:0] REG_DEAD_ZONE    = 3'd0;
    localparam logic [2:0] REG_PLUS_TRAVEL  = 3'd1;
    localparam logic [2:0] REG_MINUS_TRAVEL = 3'd2;
    localparam logic [2:0] REG_MAX_OUT      = 3'd3;
    localparam logic [2:0] REG_CURVE_MODE   = 3'd4;

    localparam logic [10:0] DEAD_ZONE_RST = 11'd50;
    localparam logic [11:0] SPAN_RST      = 12'd2080;
    localparam logic [14:0] MAX_OUT_RST   = 15'd1000;
    localparam logic [14:0] LINEAR_FULL   = 15'd1000;

    localparam int CAL_SUM_W = 20;
    localparam int DIVISOR_W = 15;

endpackage

/* rtl/joystick_axis_shaper_top.sv */
// Joystick axis shaper: calibration averaging, dead zone and curve shaping of one ADC axis.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-------------------------------------------
//  s_*      | in  | s_tvalid / s_tready    | s_tdata: sample; s_tuser: kind
//  m_*      | out | m_tvalid / m_tready    | m_tdata: axis_value; m_tuser: center_ready
//  APB      | in  | psel, penable, pready  | 5 registers at 4*i, 32-bit data
//
// Each transaction runs through idle, multiply, divide, post and done as needed: items
// that skip the arithmetic go from idle straight to done, and calibration skips multiply.
// The shared restoring divider gives 2 quotient bits per cycle and is used once for
// a calibration round or linear mapping and twice for quadratic mapping.
// Reset is asynchronous; registers and calibration state return to defaults.
// s_tready is high only while idle; a finished result waits in the output
// register while the next transaction is accepted and processed.
module joystick_axis_shaper_top #(
    parameter int CAL_SAMPLES  = 200,
    parameter int SAMPLE_WIDTH = 12
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // s_tdata: [SAMPLE_WIDTH-1:0] sample, zero padded to whole bytes
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       s_tdata,
    // s_tuser: [0] kind (0 map, 1 calibration)
    input  logic                                    s_tuser,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // m_tdata: [15:0] axis_value (signed)
    output logic [15:0]                             m_tdata,
    // m_tuser: [0] center_ready
    output logic                                    m_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [4:0]                              paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import jas_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int XW  = (SW > 11) ? SW : 11;
    localparam int AW  = (SW > 15) ? SW : 15;
    localparam int DVW = AW + DIVISOR_W;
    localparam int DVE = DVW + (DVW % 2);
    localparam int DIV_STEPS = DVE / 2;
    localparam int CW  = $clog2(DIV_STEPS);
    localparam int RW  = DIVISOR_W;
    localparam logic [CW-1:0] CNT_LAST = CW'(DIV_STEPS - 1);
    localparam logic [7:0] CAL_COUNT_END = 8'(CAL_SAMPLES);
    localparam logic [RW-1:0] CAL_DIVISOR = RW'(CAL_SAMPLES);

    // two restoring division steps
    function automatic logic [RW+DVE-1:0] div_step2(input logic [RW-1:0] r_in,
                                                    input logic [DVE-1:0] q_in,
                                                    input logic [RW-1:0] d);
        logic [RW-1:0]  rr;
        logic [DVE-1:0] qq;
        logic [RW:0]    trial;
        rr = r_in;
        qq = q_in;
        for (int i = 0; i < 2; i++)
        begin
            trial = {rr, qq[DVE-1]};
            qq = {qq[DVE-2:0], 1'b0};
            if (trial >= {1'b0, d})
            begin
                trial = trial - {1'b0, d};
                qq[0] = 1'b1;
            end
            rr = trial[RW-1:0];
        end
        return {rr, qq};
    endfunction

    // configuration registers
    logic [10:0] dead_zone_reg, dead_zone_next;
    logic [11:0] plus_travel_reg, plus_travel_next;
    logic [11:0] minus_travel_reg, minus_travel_next;
    logic [14:0] max_out_reg, max_out_next;
    logic        curve_mode_reg, curve_mode_next;

    // block state
    jas_state_t            state_reg, state_next;
    jas_op_t               op_reg, op_next;
    logic [SW-1:0]         center_reg, center_next;
    logic [CAL_SUM_W-1:0]  cal_sum_reg, cal_sum_next;
    logic [7:0]            cal_count_reg, cal_count_next;
    logic                  ready_flag_reg, ready_flag_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [CW-1:0]         cnt_reg, cnt_next;

    // datapath
    logic [AW-1:0]         mul_a_reg, mul_a_next;
    logic [14:0]           mul_b_reg, mul_b_next;
    logic [DVE-1:0]        quo_reg, quo_next;
    logic [RW-1:0]         rem_reg, rem_next;
    logic [RW-1:0]         divisor_reg, divisor_next;
    logic                  neg_reg, neg_next;
    logic [14:0]           res_mag_reg, res_mag_next;
    logic [15:0]           m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;

    logic                  cfg_write;
    logic [SW-1:0]         smp;
    logic                  positive;
    logic [SW-1:0]         mag;
    logic [XW-1:0]         mag_x;
    logic [XW-1:0]         dz_x;
    logic [SW-1:0]         beyond;
    logic [11:0]           span_sel;
    logic [11:0]           eff;
    logic [14:0]           scale;
    logic [CAL_SUM_W-1:0]  sum_inc;
    logic [7:0]            count_inc;
    logic [DVW-1:0]        product;
    logic [RW+DVE-1:0]     div_out;
    logic [14:0]           cap;
    logic [14:0]           q_capped;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_comb
    begin
        case (paddr[4:2])
            REG_DEAD_ZONE:    prdata = {21'd0, dead_zone_reg};
            REG_PLUS_TRAVEL:  prdata = {20'd0, plus_travel_reg};
            REG_MINUS_TRAVEL: prdata = {20'd0, minus_travel_reg};
            REG_MAX_OUT:      prdata = {17'd0, max_out_reg};
            REG_CURVE_MODE:   prdata = {31'd0, curve_mode_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // input side arithmetic, used on the accept cycle
    assign smp       = s_tdata[SW-1:0];
    assign positive  = smp > center_reg;
    assign mag       = positive ? (smp - center_reg) : (center_reg - smp);
    assign mag_x     = XW'(mag);
    assign dz_x      = XW'(dead_zone_reg);
    assign beyond    = SW'(mag_x - dz_x);
    assign span_sel  = positive ? plus_travel_reg : minus_travel_reg;
    assign eff       = ({1'b0, span_sel} <= ({2'b0, dead_zone_reg} + 13'd1)) ? 12'd1
                     : 12'(span_sel - {1'b0, dead_zone_reg});
    assign scale     = curve_mode_reg ? LINEAR_FULL : max_out_reg;
    assign sum_inc   = cal_sum_reg + CAL_SUM_W'(smp);
    assign count_inc = cal_count_reg + 8'd1;

    // shared multiplier and divider
    assign product  = mul_a_reg * mul_b_reg;
    assign div_out  = div_step2(rem_reg, quo_reg, divisor_reg);
    assign cap      = (op_reg == OP_LIN) ? LINEAR_FULL : max_out_reg;
    assign q_capped = (quo_reg > DVE'(cap)) ? cap : quo_reg[14:0];

    always_comb
    begin
        dead_zone_next    = dead_zone_reg;
        plus_travel_next  = plus_travel_reg;
        minus_travel_next = minus_travel_reg;
        max_out_next      = max_out_reg;
        curve_mode_next   = curve_mode_reg;
        state_next      = state_reg;
        op_next         = op_reg;
        center_next     = center_reg;
        cal_sum_next    = cal_sum_reg;
        cal_count_next  = cal_count_reg;
        ready_flag_next = ready_flag_reg;
        m_tvalid_next   = m_tvalid_reg;
        cnt_next        = cnt_reg;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        neg_next        = neg_reg;
        res_mag_next    = res_mag_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        if (cfg_write)
        begin
            case (paddr[4:2])
                REG_DEAD_ZONE:    dead_zone_next    = pwdata[10:0];
                REG_PLUS_TRAVEL:  plus_travel_next  = pwdata[11:0];
                REG_MINUS_TRAVEL: minus_travel_next = pwdata[11:0];
                REG_MAX_OUT:      max_out_next      = pwdata[14:0];
                REG_CURVE_MODE:   curve_mode_next   = pwdata[0];
                default:          ;
            endcase
        end

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_mag_next = 15'd0;
                    neg_next     = !positive;
                    state_next   = ST_DONE;
                    if (s_tuser)
                    begin
                        if (count_inc >= CAL_COUNT_END)
                        begin
                            cal_sum_next   = '0;
                            cal_count_next = 8'd0;
                            op_next        = OP_CAL;
                            quo_next       = DVE'(sum_inc);
                            rem_next       = '0;
                            divisor_next   = CAL_DIVISOR;
                            cnt_next       = '0;
                            state_next     = ST_DIV;
                        end
                        else
                        begin
                            cal_sum_next   = sum_inc;
                            cal_count_next = count_inc;
                        end
                    end
                    else if (mag != '0 && mag_x >= dz_x
                             && (curve_mode_reg || max_out_reg != 15'd0))
                    begin
                        op_next      = curve_mode_reg ? OP_LIN : OP_SQR;
                        mul_a_next   = AW'(beyond);
                        mul_b_next   = scale;
                        divisor_next = RW'(eff);
                        state_next   = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                quo_next   = DVE'(product);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = div_out[RW+DVE-1:DVE];
                quo_next = div_out[DVE-1:0];
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CNT_LAST)
                    state_next = ST_POST;
            end
            ST_POST:
            begin
                state_next = ST_DONE;
                case (op_reg)
                    OP_CAL:
                    begin
                        center_next     = quo_reg[SW-1:0];
                        ready_flag_next = 1'b1;
                    end
                    OP_LIN:
                        res_mag_next = q_capped;
                    OP_SQR:
                    begin
                        // first pass gave the capped linear term; square it next
                        mul_a_next   = AW'(q_capped);
                        mul_b_next   = q_capped;
                        divisor_next = max_out_reg;
                        op_next      = OP_SQR_FIN;
                        state_next   = ST_MUL;
                    end
                    OP_SQR_FIN:
                        res_mag_next = q_capped;
                    default: ;
                endcase
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = neg_reg ? (16'd0 - {1'b0, res_mag_reg})
                                            : {1'b0, res_mag_reg};
                    m_tuser_next  = ready_flag_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg    <= DEAD_ZONE_RST;
            plus_travel_reg  <= SPAN_RST;
            minus_travel_reg <= SPAN_RST;
            max_out_reg      <= MAX_OUT_RST;
            curve_mode_reg   <= 1'b0;
            op_reg         <= OP_CAL;
            center_reg     <= '0;
            cal_sum_reg    <= '0;
            cal_count_reg  <= 8'd0;
            ready_flag_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            dead_zone_reg    <= dead_zone_next;
            plus_travel_reg  <= plus_travel_next;
            minus_travel_reg <= minus_travel_next;
            max_out_reg      <= max_out_next;
            curve_mode_reg   <= curve_mode_next;
            op_reg         <= op_next;
            center_reg     <= center_next;
            cal_sum_reg    <= cal_sum_next;
            cal_count_reg  <= cal_count_next;
            ready_flag_reg <= ready_flag_next;
            m_tvalid_reg   <= m_tvalid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
        res_mag_reg <= res_mag_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

`ifndef SYNTH
    a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ready_flag_reg |=> ready_flag_reg)
        else $error("center_ready dropped after being set");

    a_cal_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_count_reg < CAL_COUNT_END)
        else $error("calibration count reached the round length");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (divisor_reg != '0))
        else $error("division by zero in shared divider");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while previous transaction in flight");
`endif

endmodule

/* verif/tb_joystick_axis_shaper_top.sv */
// Testbench for the joystick axis shaper: stream stimulus, APB setup and a result scoreboard.
`timescale 1ns / 100ps

module tb_joystick_axis_shaper_top;
    import jas_pkg::*;

    localparam logic KIND_MAP = 1'b0;
    localparam logic KIND_CAL = 1'b1;
    localparam int CAL_ROUND = 200;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 230;

    typedef struct packed {
        logic [15:0] axis_value;
        logic        center_ready;
    } axis_result_t;

    class axis_scoreboard;
        logic [10:0]  dead_zone;
        logic [11:0]  plus_travel;
        logic [11:0]  minus_travel;
        logic [14:0]  max_out;
        logic         curve_lin;
        logic [11:0]  center;
        logic [19:0]  cal_sum;
        logic [7:0]   cal_cnt;
        logic         ready;
        axis_result_t pending_q[$];
        int           errors;

        function new();
            dead_zone    = DEAD_ZONE_RST;
            plus_travel  = SPAN_RST;
            minus_travel = SPAN_RST;
            max_out   = MAX_OUT_RST;
            curve_lin = 1'b0;
            center    = '0;
            cal_sum   = '0;
            cal_cnt   = '0;
            ready     = 1'b0;
            errors    = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_DEAD_ZONE:    dead_zone    = val[10:0];
                REG_PLUS_TRAVEL:  plus_travel  = val[11:0];
                REG_MINUS_TRAVEL: minus_travel = val[11:0];
                REG_MAX_OUT:      max_out      = val[14:0];
                REG_CURVE_MODE:   curve_lin    = val[0];
                default: ;
            endcase
        endfunction

        // signed shaped value for a mapped sample against the current center
        function logic [15:0] shape_axis(logic [11:0] smp);
            logic            pos;
            int unsigned     mag, beyond, spn, eff;
            longint unsigned lin, crv;
            logic [15:0]     m;
            pos = smp > center;
            mag = pos ? smp - center : center - smp;
            if (mag == 0 || mag < dead_zone)
                return '0;
            spn = pos ? plus_travel : minus_travel;
            if (spn <= dead_zone + 1)
                spn = dead_zone + 1;
            eff = spn - dead_zone;
            beyond = mag - dead_zone;
            if (curve_lin) begin
                lin = longint'(beyond) * LINEAR_FULL / eff;
                crv = (lin > LINEAR_FULL) ? LINEAR_FULL : lin;
            end
            else if (max_out == 0) begin
                crv = 0;
            end
            else begin
                lin = longint'(beyond) * max_out / eff;
                if (lin > max_out)
                    lin = max_out;
                crv = lin * lin / max_out;
                if (crv > max_out)
                    crv = max_out;
            end
            m = crv[15:0];
            return pos ? m : -m;
        endfunction

        function void note_sample(logic kind, logic [11:0] smp);
            axis_result_t r;
            r.axis_value = '0;
            if (kind == KIND_CAL) begin
                cal_sum = cal_sum + smp;
                cal_cnt = cal_cnt + 1;
                if (cal_cnt >= CAL_ROUND) begin
                    center  = 12'(cal_sum / CAL_ROUND);
                    cal_sum = '0;
                    cal_cnt = '0;
                    ready   = 1'b1;
                end
            end
            else begin
                r.axis_value = shape_axis(smp);
            end
            r.center_ready = ready;
            pending_q.push_back(r);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch @%0t: %s", $time, msg);
        endfunction

        function void check_result(logic [15:0] data, logic user);
            axis_result_t r;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result axis=%0d ready=%0b",
                                 $signed(data), user));
                return;
            end
            r = pending_q.pop_front();
            if (data !== r.axis_value)
                report($sformatf("axis_value exp %0d got %0d",
                                 $signed(r.axis_value), $signed(data)));
            if (user !== r.center_ready)
                report($sformatf("center_ready exp %0b got %0b", r.center_ready, user));
        endfunction

        function void close_out();
            while (pending_q.size() != 0) begin
                void'(pending_q.pop_front());
                report("result never arrived");
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic [15:0] s_tdata;   // [11:0] sample, [15:12] zero
    logic        s_tuser;   // [0] kind
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] m_tdata;   // [15:0] axis_value
    logic        m_tuser;   // [0] center_ready
    logic        m_tvalid;
    logic        m_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    axis_scoreboard sb = new();
    int unsigned    gap_pct;
    int unsigned    stall_pct;

    joystick_axis_shaper_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_joystick_axis_shaper_top: errors");
        $finish;
    end

    // both handshakes observed at the rising edge; inputs are noted first
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_sample(s_tuser, s_tdata[11:0]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
        end
    end

    // output backpressure in random bursts
    initial
    begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(logic kind, int smp);
        @(negedge clk);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, 12'(smp)};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] idx, int unsigned val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    function automatic int clamp_sample(int v);
        if (v < 0)
            return 0;
        if (v > 4095)
            return 4095;
        return v;
    endfunction

    // map samples: full range, across the travel, and around the band edge
    function automatic int map_sample();
        int dz, off;
        dz = sb.dead_zone;
        case ($urandom_range(0, 4))
            0, 1: return $urandom_range(0, 4095);
            2, 3: off = dz + $urandom_range(0, 2500);
            default: off = dz + $urandom_range(0, 4) - 2;
        endcase
        return clamp_sample($urandom_range(0, 1) ? sb.center + off : sb.center - off);
    endfunction

    task automatic random_config();
        case ($urandom_range(0, 5))
            0: apb_write(REG_DEAD_ZONE, 0);
            1: apb_write(REG_DEAD_ZONE, 2047);
            default: apb_write(REG_DEAD_ZONE, $urandom_range(0, 200));
        endcase
        case ($urandom_range(0, 5))
            0: apb_write(REG_PLUS_TRAVEL, 0);
            1: apb_write(REG_PLUS_TRAVEL, 4095);
            default: apb_write(REG_PLUS_TRAVEL, $urandom_range(200, 2500));
        endcase
        case ($urandom_range(0, 5))
            0: apb_write(REG_MINUS_TRAVEL, 0);
            1: apb_write(REG_MINUS_TRAVEL, 4095);
            default: apb_write(REG_MINUS_TRAVEL, $urandom_range(200, 2500));
        endcase
        case ($urandom_range(0, 4))
            0: apb_write(REG_MAX_OUT, 1);
            1: apb_write(REG_MAX_OUT, 32767);
            default: apb_write(REG_MAX_OUT, $urandom_range(1, 32767));
        endcase
        apb_write(REG_CURVE_MODE, $urandom_range(0, 1));
    endtask

    initial
    begin
        int base, spread, done;
        rst_n    = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_MAP;
        s_tvalid = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        gap_pct  = 0;
        stall_pct = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // defaults, uncalibrated center at zero
        send_item(KIND_MAP, 0);
        send_item(KIND_MAP, 49);
        send_item(KIND_MAP, 50);
        send_item(KIND_MAP, 51);
        send_item(KIND_MAP, 4095);
        send_item(KIND_CAL, 4095);
        drain();
        // no band, span floored to one count, linear
        apb_write(REG_DEAD_ZONE, 0);
        apb_write(REG_PLUS_TRAVEL, 0);
        apb_write(REG_CURVE_MODE, 1);
        send_item(KIND_MAP, 1);
        send_item(KIND_MAP, 4095);
        drain();
        // quadratic with zero full scale
        apb_write(REG_CURVE_MODE, 0);
        apb_write(REG_MAX_OUT, 0);
        send_item(KIND_MAP, 4095);
        drain();
        // widest band, widest span, largest full scale
        apb_write(REG_DEAD_ZONE, 2047);
        apb_write(REG_PLUS_TRAVEL, 4095);
        apb_write(REG_MAX_OUT, 32767);
        send_item(KIND_MAP, 4095);
        send_item(KIND_MAP, 3500);
        send_item(KIND_MAP, 2047);
        send_item(KIND_MAP, 2046);
        drain();
        apb_write(REG_DEAD_ZONE, 10);
        apb_write(REG_MAX_OUT, 1);
        send_item(KIND_MAP, 3000);
        send_item(KIND_MAP, 11);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            random_config();
            if (p < PHASES - 2) begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 30;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 30;
                endcase
            end
            else begin
                gap_pct = 0;
                stall_pct = 0;
            end
            done = 0;
            // a full calibration round around a random or extreme center
            if (p % 3 == 0) begin
                case ($urandom_range(0, 3))
                    0: base = 0;
                    1: base = 4095;
                    default: base = $urandom_range(0, 4095);
                endcase
                spread = $urandom_range(0, 1) ? 0 : $urandom_range(1, 300);
                for (int i = 0; i < CAL_ROUND; i++)
                    send_item(KIND_CAL, clamp_sample(base + $urandom_range(0, 2 * spread)
                                                     - spread));
                done = CAL_ROUND;
            end
            for (int i = done; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(KIND_CAL, $urandom_range(0, 4095));
                else
                    send_item(KIND_MAP, map_sample());
            end
            drain();
        end

        repeat (40) @(posedge clk);
        sb.close_out();
        if (sb.errors == 0)
            $display("tb_joystick_axis_shaper_top: clean");
        else
            $display("tb_joystick_axis_shaper_top: errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/jas_pkg.sv
rtl/joystick_axis_shaper_top.sv
verif/tb_joystick_axis_shaper_top.sv
